// ----- src/jse_pkg.sv -----
// Shared types, constants and lookup functions of the JSON string escaper.
package jse_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int BYTE_WIDTH      = 8;
    localparam int NULL_LEN        = 9;
    localparam int IDX_WIDTH       = $clog2(NULL_LEN);

    localparam logic [BYTE_WIDTH-1:0] CH_NUL       = 8'h00;
    localparam logic [BYTE_WIDTH-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_WIDTH-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_WIDTH-1:0] CH_BS        = 8'h08;
    localparam logic [BYTE_WIDTH-1:0] CH_FF        = 8'h0C;
    localparam logic [BYTE_WIDTH-1:0] CH_LF        = 8'h0A;
    localparam logic [BYTE_WIDTH-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_WIDTH-1:0] CH_TAB       = 8'h09;

    localparam logic [IDX_WIDTH-1:0] ESC_LAST_IDX  = IDX_WIDTH'(1);
    localparam logic [IDX_WIDTH-1:0] NULL_LAST_IDX = IDX_WIDTH'(NULL_LEN - 1);

    typedef enum logic [1:0] {
        JOB_PLAIN,
        JOB_ESC,
        JOB_NULL
    } t_job_kind;

    // One input word's worth of output: the kind of run and its payload byte.
    typedef struct packed {
        t_job_kind             kind;
        logic [BYTE_WIDTH-1:0] data;
    } t_job;

    // Letter that follows the backslash, or zero when the byte passes as is.
    function automatic logic [BYTE_WIDTH-1:0] escape_letter(input logic [BYTE_WIDTH-1:0] c);
        logic [BYTE_WIDTH-1:0] e;
        unique case (c)
            CH_QUOTE:     e = CH_QUOTE;
            CH_BACKSLASH: e = CH_BACKSLASH;
            CH_BS:        e = 8'h62;
            CH_FF:        e = 8'h66;
            CH_LF:        e = 8'h6E;
            CH_CR:        e = 8'h72;
            CH_TAB:       e = 8'h74;
            default:      e = CH_NUL;
        endcase
        return e;
    endfunction

    // Characters of the text "<nullptr>".
    function automatic logic [BYTE_WIDTH-1:0] null_char(input logic [IDX_WIDTH-1:0] idx);
        logic [BYTE_WIDTH-1:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h3C;
            4'd1:    ch = 8'h6E;
            4'd2:    ch = 8'h75;
            4'd3:    ch = 8'h6C;
            4'd4:    ch = 8'h6C;
            4'd5:    ch = 8'h70;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h72;
            4'd8:    ch = 8'h3E;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

// ----- src/json_string_escaper.sv -----
// Top level of the streaming JSON string escaper.
//
// Input stream: one string byte per word on i_s_tdata, i_s_tlast marks the
// last byte of a string and i_s_tuser flags a missing string, which emits the
// text "<nullptr>" and ends the string. Output stream: one escaped byte per
// word on o_m_tdata, with o_m_tlast high on the last byte caused by an input
// word. Quote, backslash and the five control escapes become a backslash
// pair; a zero byte, or reaching the length limit, drops the rest of the
// string. The limit goes in through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, which the block does not enforce.
// Decisions are taken as a word is accepted; the emitter turns the word into
// one, two or nine output words at one per cycle unless the output stalls.
// Each run waits in the pending register and its bytes then pass through the
// output register; a new word is accepted as the pending run hands on its
// last byte. When the receiver stalls, the output register holds its word
// and the input side stops once the pending run cannot move. Reset empties
// both stages, clears the count and stop flag, and sets the limit to its maximum.
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [BYTE_WIDTH-1:0] i_s_tdata,   // [7:0] char_byte
    input  logic                  i_s_tlast,   // end_of_string
    input  logic                  i_s_tuser,   // [0] null_string
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [BYTE_WIDTH-1:0] o_m_tdata,   // [7:0] out_byte
    output logic                  o_m_tlast,   // run_last
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_WIDTH-1:0]  i_cfg_wr_data
);

    localparam logic [COUNT_WIDTH+CFG_WIDTH-1:0] MAX_RESET_EXT =
        (COUNT_WIDTH+CFG_WIDTH)'({CFG_WIDTH{1'b1}});

    logic [COUNT_WIDTH-1:0]      r_max_len;
    logic [COUNT_WIDTH:0]        r_count;
    logic                        r_stopped;
    logic [COUNT_WIDTH:0]        n_count;
    logic                        n_stopped;
    logic [COUNT_WIDTH+CFG_WIDTH-1:0] cfg_ext;

    logic                  accept;
    logic                  job_ready;
    logic                  job_valid;
    t_job                  job;
    logic [BYTE_WIDTH-1:0] letter;
    logic                  drop;

    assign cfg_ext = (COUNT_WIDTH+CFG_WIDTH)'(i_cfg_wr_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_RESET_EXT[COUNT_WIDTH-1:0];
        end else if (i_cfg_wr_en) begin
            r_max_len <= cfg_ext[COUNT_WIDTH-1:0];
        end
    end

    assign o_s_tready = job_ready;
    assign accept     = i_s_tvalid && job_ready;
    assign letter     = escape_letter(i_s_tdata);
    assign drop       = r_stopped || (i_s_tdata == CH_NUL)
                        || (r_count >= {1'b0, r_max_len});

    always_comb begin
        job_valid = 1'b0;
        job.kind  = JOB_PLAIN;
        job.data  = i_s_tdata;
        n_count   = r_count;
        n_stopped = r_stopped;
        if (i_s_tuser) begin
            job_valid = i_s_tvalid;
            job.kind  = JOB_NULL;
            n_count   = '0;
            n_stopped = 1'b0;
        end else begin
            if (drop) begin
                n_stopped = 1'b1;
            end else if (letter != CH_NUL) begin
                job_valid = i_s_tvalid;
                job.kind  = JOB_ESC;
                job.data  = letter;
                n_count   = r_count + (COUNT_WIDTH+1)'(2);
            end else begin
                job_valid = i_s_tvalid;
                n_count   = r_count + (COUNT_WIDTH+1)'(1);
            end
            if (i_s_tlast) begin
                n_count   = '0;
                n_stopped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else if (accept) begin
            r_count   <= n_count;
            r_stopped <= n_stopped;
        end
    end

    jse_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ----- src/jse_emitter.sv -----
// Output sequencer: holds one pending run and emits it a byte at a time into an output register.
module jse_emitter
    import jse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  t_job                  i_job,
    output logic                  o_job_ready,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [BYTE_WIDTH-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    logic                  r_job_valid;
    t_job                  r_job;
    logic [IDX_WIDTH-1:0]  r_idx;
    logic                  r_out_valid;
    logic [BYTE_WIDTH-1:0] r_out_byte;
    logic                  r_out_last;

    logic                  out_free;
    logic                  cur_last;
    logic [BYTE_WIDTH-1:0] cur_byte;
    logic                  job_done;

    always_comb begin
        unique case (r_job.kind)
            JOB_PLAIN: begin
                cur_byte = r_job.data;
                cur_last = 1'b1;
            end
            JOB_ESC: begin
                cur_byte = (r_idx == '0) ? CH_BACKSLASH : r_job.data;
                cur_last = (r_idx == ESC_LAST_IDX);
            end
            JOB_NULL: begin
                cur_byte = null_char(r_idx);
                cur_last = (r_idx == NULL_LAST_IDX);
            end
            default: begin
                cur_byte = r_job.data;
                cur_last = 1'b1;
            end
        endcase
    end

    assign out_free    = !r_out_valid || i_m_tready;
    assign job_done    = r_job_valid && out_free && cur_last;
    assign o_job_ready = !r_job_valid || job_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (i_job_valid && o_job_ready) begin
            r_job_valid <= 1'b1;
            r_idx       <= '0;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end else if (r_job_valid && out_free) begin
            r_idx <= r_idx + IDX_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid && o_job_ready) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_job_valid) begin
            r_out_byte <= cur_byte;
            r_out_last <= cur_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- src/jse_checker.sv -----
// Port-level checks of the JSON string escaper, bound to the top level.
module jse_checker
    import jse_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [BYTE_WIDTH-1:0] o_m_tdata,
    input logic                  o_m_tlast
);

    // A stalled output word keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // Reset leaves both stages empty and the input side open.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not empty after reset");

    // A zero byte is never emitted.
    a_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata != CH_NUL)
        else $error("zero byte emitted");

    // Bytes that must be escaped never leave as raw control characters.
    a_no_raw_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata == CH_BS || o_m_tdata == CH_FF || o_m_tdata == CH_LF
                         || o_m_tdata == CH_CR || o_m_tdata == CH_TAB))
        else $error("unescaped control byte emitted");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ----- verif/tb_json_string_escaper.sv -----
// Self-checking testbench for the streaming JSON string escaper.
module tb_json_string_escaper;
    import jse_pkg::*;

    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 64;
    localparam int ESC_CODES    = 7;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam logic [8*NULL_LEN-1:0] NULL_TEXT = "<nullptr>";

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data;
        logic                  last;
    } t_out_word;

    // One row of the directed table. A row either writes the length limit or
    // sends one word; typed rows carry their expected output inline.
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_WIDTH-1:0]  value;
        logic                  eos;
        logic                  nul;
        logic                  typed;
        logic [1:0]            n;
        logic [BYTE_WIDTH-1:0] b0;
        logic [BYTE_WIDTH-1:0] b1;
    } t_dir_row;

    localparam int DIR_ROWS = 28;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{1'b0, 16'h0041, 1'b0, 1'b0, 1'b1, 2'd1, 8'h41, 8'h00},
        '{1'b0, 16'h00FF, 1'b0, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00},
        '{1'b0, 16'h0001, 1'b0, 1'b0, 1'b1, 2'd1, 8'h01, 8'h00},
        '{1'b0, 16'h0022, 1'b0, 1'b0, 1'b1, 2'd2, 8'h5C, 8'h22},
        '{1'b0, 16'h005C, 1'b0, 1'b0, 1'b1, 2'd2, 8'h5C, 8'h5C},
        '{1'b0, 16'h0008, 1'b0, 1'b0, 1'b1, 2'd2, 8'h5C, 8'h62},
        '{1'b0, 16'h000C, 1'b0, 1'b0, 1'b1, 2'd2, 8'h5C, 8'h66},
        '{1'b0, 16'h000A, 1'b0, 1'b0, 1'b1, 2'd2, 8'h5C, 8'h6E},
        '{1'b0, 16'h000D, 1'b0, 1'b0, 1'b1, 2'd2, 8'h5C, 8'h72},
        '{1'b0, 16'h0009, 1'b0, 1'b0, 1'b1, 2'd2, 8'h5C, 8'h74},
        '{1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0042, 1'b0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0043, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h00AA, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0078, 1'b1, 1'b0, 1'b1, 2'd1, 8'h78, 8'h00},
        '{1'b0, 16'h0055, 1'b1, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b1, 16'h0003, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0061, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0022, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0062, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0063, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0064, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0000, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b1, 16'h0002, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0065, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0009, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 16'h0066, 1'b1, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_s_tvalid    = 1'b0;
    logic                  o_s_tready;
    logic [BYTE_WIDTH-1:0] i_s_tdata     = '0;
    logic                  i_s_tlast     = 1'b0;
    logic                  i_s_tuser     = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready    = 1'b0;
    logic [BYTE_WIDTH-1:0] o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_WIDTH-1:0]  i_cfg_wr_data = '0;

    // Shadow copy of the block's length limit and per-string state.
    logic [CFG_WIDTH-1:0]       limit_len = '1;
    logic [COUNT_WIDTH_DEF:0]   out_count = '0;
    logic                       halted    = 1'b0;

    t_out_word escaped_bytes [$];
    t_out_word want;
    int        errors        = 0;
    int        cycle_count   = 0;
    int        send_idle_pct = 36;
    int        recv_idle_pct = 50;
    int        hold_left     = 0;
    bit        hold_go       = 1'b0;

    json_string_escaper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [BYTE_WIDTH-1:0] json_letter(input logic [BYTE_WIDTH-1:0] c);
        unique case (c)
            CH_QUOTE, CH_BACKSLASH: json_letter = c;
            CH_BS:                  json_letter = 8'h62;
            CH_FF:                  json_letter = 8'h66;
            CH_LF:                  json_letter = 8'h6E;
            CH_CR:                  json_letter = 8'h72;
            CH_TAB:                 json_letter = 8'h74;
            default:                json_letter = CH_NUL;
        endcase
    endfunction

    // Advances the shadow state by one input word and returns the escaped text.
    function automatic int escape_step(input logic [BYTE_WIDTH-1:0] c, input logic eos,
                                       input logic nul,
                                       output logic [BYTE_WIDTH-1:0] text [NULL_LEN]);
        int n;
        logic [BYTE_WIDTH-1:0] letter;
        n = 0;
        text = '{default: CH_NUL};
        if (nul) begin
            for (int i = 0; i < NULL_LEN; i++) begin
                text[i] = NULL_TEXT[BYTE_WIDTH*(NULL_LEN-1-i) +: BYTE_WIDTH];
            end
            out_count = '0;
            halted = 1'b0;
            return NULL_LEN;
        end
        if (halted || c == CH_NUL || out_count >= {1'b0, limit_len}) begin
            halted = 1'b1;
        end else begin
            letter = json_letter(c);
            if (letter != CH_NUL) begin
                text[0] = CH_BACKSLASH;
                text[1] = letter;
                n = 2;
            end else begin
                text[0] = c;
                n = 1;
            end
            out_count = out_count + (COUNT_WIDTH_DEF+1)'(n);
        end
        if (eos) begin
            out_count = '0;
            halted = 1'b0;
        end
        return n;
    endfunction

    function automatic logic [BYTE_WIDTH-1:0] pick_byte();
        logic [BYTE_WIDTH-1:0] esc [ESC_CODES];
        int r;
        esc = '{CH_QUOTE, CH_BACKSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB};
        r = $urandom_range(99);
        if (r < 12) return esc[$urandom_range(ESC_CODES-1)];
        if (r < 16) return CH_NUL;
        if (r < 28) return BYTE_WIDTH'($urandom_range(255));
        return BYTE_WIDTH'($urandom_range(8'h7E, 8'h20));
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic wait_drained();
        while (escaped_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_word(input logic [BYTE_WIDTH-1:0] c, input logic eos, input logic nul,
                             input logic typed, input logic [1:0] typed_n,
                             input logic [BYTE_WIDTH-1:0] b0, input logic [BYTE_WIDTH-1:0] b1);
        logic [BYTE_WIDTH-1:0] text [NULL_LEN];
        int n;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= eos;
        i_s_tuser  <= nul;
        do @(posedge i_clk); while (!o_s_tready);
        n = escape_step(c, eos, nul, text);
        if (typed) begin
            if (typed_n == 2'd1) escaped_bytes.push_back(t_out_word'{b0, 1'b1});
            if (typed_n == 2'd2) begin
                escaped_bytes.push_back(t_out_word'{b0, 1'b0});
                escaped_bytes.push_back(t_out_word'{b1, 1'b1});
            end
        end else begin
            for (int i = 0; i < n; i++) escaped_bytes.push_back(t_out_word'{text[i], i == n - 1});
        end
    endtask

    // All expected words drain before the write, and a short idle gap follows
    // before the limit changes.
    task automatic set_limit(input logic [CFG_WIDTH-1:0] value);
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        limit_len = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (escaped_bytes.size() == 0) begin
                note_error($sformatf("unexpected word %h last %b", o_m_tdata, o_m_tlast));
            end else begin
                want = escaped_bytes.pop_front();
                if (o_m_tdata !== want.data || o_m_tlast !== want.last) begin
                    note_error($sformatf("expected %h last %b, got %h last %b",
                                         want.data, want.last, o_m_tdata, o_m_tlast));
                end
            end
        end
    end

    initial begin
        int sent;
        int len;
        bit paused;
        logic [CFG_WIDTH-1:0] lim;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].is_cfg) begin
                set_limit(DIRECTED[r].value);
            end else begin
                send_word(DIRECTED[r].value[BYTE_WIDTH-1:0], DIRECTED[r].eos, DIRECTED[r].nul,
                          DIRECTED[r].typed, DIRECTED[r].n, DIRECTED[r].b0, DIRECTED[r].b1);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            unique case (ph)
                0: lim = '1;
                1: lim = CFG_WIDTH'($urandom_range(12, 2));
                2: lim = CFG_WIDTH'(1);
                3: lim = '0;
                4: lim = CFG_WIDTH'($urandom_range(16'hFFFF));
                default: lim = CFG_WIDTH'($urandom_range(8, 3));
            endcase
            set_limit(lim);
            send_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 50 : 0;
            recv_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 36 : 0;
            // A long output stall while words keep coming fills the block.
            if (ph == 1) hold_go = 1'b1;
            sent = 0;
            paused = 1'b0;
            while (sent < PHASE_WORDS) begin
                if (ph == 3 && !paused && sent >= PHASE_WORDS / 2) begin
                    i_s_tvalid <= 1'b0;
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 6) begin
                    send_word(pick_byte(), 1'($urandom_range(1)), 1'b1, 1'b0, 2'd0,
                              8'h00, 8'h00);
                    sent++;
                end else begin
                    len = $urandom_range(10, 1);
                    for (int k = 0; k < len; k++) begin
                        send_word(pick_byte(), (k == len - 1) || ($urandom_range(99) < 3),
                                  $urandom_range(99) < 2, 1'b0, 2'd0, 8'h00, 8'h00);
                        sent++;
                    end
                end
            end
        end

        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
